// ===== sv/ipv4rx_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4rx_pkg
// shared types, constants and helpers of the ipv4 receive header classifier
// ----------------------------------------------------------------------------
package ipv4rx_pkg;

  localparam int NUM_IFACES = 3;
  localparam int IDX_W      = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_BASE  = 3'd1;

  localparam logic [3:0]  IP_VERSION = 4'd4;
  localparam logic [3:0]  MIN_IHL    = 4'd5;
  localparam logic [15:0] IHL_UNIT   = 16'd4;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] SUM_OK     = 16'hFFFF;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [3:0]  MCAST_TOP  = 4'hE;
  localparam logic [1:0]  MATCH_NONE = 2'd3;

  // header word positions
  localparam logic [4:0] POS_FRAG   = 5'd3;
  localparam logic [4:0] POS_PROTO  = 5'd4;
  localparam logic [4:0] POS_DST_HI = 5'd8;
  localparam logic [4:0] POS_DST_LO = 5'd9;

  typedef enum logic [3:0] {
    V_UDP     = 4'd0,
    V_ICMP    = 4'd1,
    V_BADVER  = 4'd2,
    V_SHORT   = 4'd3,
    V_BADSUM  = 4'd4,
    V_NOTUS   = 4'd5,
    V_FRAG    = 4'd6,
    V_OPTS    = 4'd7,
    V_TCP     = 4'd8,
    V_UNREACH = 4'd9,
    V_SILENT  = 4'd10
  } verdict_e;

  typedef struct packed {
    logic [15:0] hdr_word;
    logic        pkt_start;
    logic [15:0] buf_bytes;
    logic [1:0]  rx_iface;
  } hdr_item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [1:0]  match_iface;
    logic [7:0]  protocol;
    logic [31:0] rx_total;
    logic [31:0] drop_total;
  } vrd_item_t;

  typedef struct packed {
    logic [1:0]                  iface_count;
    logic [NUM_IFACES-1:0][31:0] addr;
    logic [NUM_IFACES-1:0][31:0] mask;
  } cfg_t;

  function automatic logic is_bcast(logic [31:0] a, logic [31:0] m);
    return ((a & ~m) == ~m) || (a == ALL_ONES);
  endfunction

endpackage

// ===== sv/ipv4rx_hdr_if.sv =====
// ----------------------------------------------------------------------------
// ipv4rx_hdr_if
// header word channel: valid, ready and one header item
// ----------------------------------------------------------------------------
interface ipv4rx_hdr_if;
  import ipv4rx_pkg::*;

  logic      valid;
  logic      ready;
  hdr_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ipv4rx_vrd_if.sv =====
// ----------------------------------------------------------------------------
// ipv4rx_vrd_if
// verdict channel: valid, ready and one verdict item
// ----------------------------------------------------------------------------
interface ipv4rx_vrd_if;
  import ipv4rx_pkg::*;

  logic      valid;
  logic      ready;
  vrd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ipv4_rx_header_classifier.sv =====
// ----------------------------------------------------------------------------
// ipv4_rx_header_classifier
// ipv4 receive header check, interface match and per-packet verdict
// ----------------------------------------------------------------------------
// hdr_i takes one 16-bit header word per transaction, pkt_start set on the
// first word together with buf_bytes and rx_iface. vrd_o gives one verdict
// transaction per packet with the matched interface, the protocol byte and
// the receive and drop counters after that packet.
// a bad version or short header gives its verdict on the first word, every
// other verdict comes on the last header word; words outside a packet are
// dropped without a verdict, and a new pkt_start abandons an open packet.
// throughput: one word per cycle while vrd_o is not stalled, set by the single
// pass from the input register through checksum fold, interface compare and
// verdict select. An accepted word passes the input register and then the
// result register, from which its verdict is offered on vrd_o.
// when vrd_o stalls, the input register still takes one word and then
// hdr_i.ready drops until the verdict transaction completes. Reset clears the
// counters, packet state and interface table. The user must load registers by
// the write port (cfg_we_i, cfg_idx_i, cfg_wdata_i) while idle; not enforced.
// ----------------------------------------------------------------------------
module ipv4_rx_header_classifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ipv4rx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ipv4rx_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  ipv4rx_hdr_if.sink                        hdr_i,
  ipv4rx_vrd_if.source                      vrd_o
);
  import ipv4rx_pkg::*;

  cfg_t      cfg;
  logic      s1_valid;
  hdr_item_t s1_data;
  logic      advance;

  ipv4rx_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ipv4rx_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hdr_i     (hdr_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .data_o    (s1_data)
  );

  ipv4rx_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (s1_valid),
    .data_i    (s1_data),
    .advance_o (advance),
    .vrd_o     (vrd_o)
  );

  // input only stalls behind a held verdict
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hdr_i.ready |-> (vrd_o.valid && !vrd_o.ready))
    else $error("input stalled without output back-pressure");

  // a pending word is kept while the core cannot take it
  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !advance) |=> s1_valid)
    else $error("pending header word lost");

  // early verdicts carry no interface and no protocol
  a_early_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vrd_o.valid && ((vrd_o.data.verdict == V_BADVER) || (vrd_o.data.verdict == V_SHORT)))
    |-> ((vrd_o.data.match_iface == MATCH_NONE) && (vrd_o.data.protocol == 8'd0)))
    else $error("early verdict with interface or protocol set");

endmodule

// ===== sv/ipv4rx_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ipv4rx_cfg_regs
// interface table and count, written through the plain write port
// ----------------------------------------------------------------------------
module ipv4rx_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ipv4rx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ipv4rx_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output ipv4rx_pkg::cfg_t                  cfg_o
);
  import ipv4rx_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IFACE_COUNT) begin
        cfg_q.iface_count <= cfg_wdata_i[1:0];
      end
      for (int i = 0; i < NUM_IFACES; i++) begin
        if (cfg_idx_i == CFG_IFACE_BASE + CFG_IDX_W'(2 * i)) begin
          cfg_q.addr[i] <= cfg_wdata_i;
        end
        if (cfg_idx_i == CFG_IFACE_BASE + CFG_IDX_W'(2 * i + 1)) begin
          cfg_q.mask[i] <= cfg_wdata_i;
        end
      end
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/ipv4rx_in_stage.sv =====
// ----------------------------------------------------------------------------
// ipv4rx_in_stage
// input register for header words, holds a word until the core takes it
// ----------------------------------------------------------------------------
module ipv4rx_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ipv4rx_hdr_if.sink            hdr_i,
  input  logic                  advance_i,
  output logic                  valid_o,
  output ipv4rx_pkg::hdr_item_t data_o
);
  import ipv4rx_pkg::*;

  logic      valid_q;
  hdr_item_t data_q;

  assign hdr_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (hdr_i.ready) begin
      valid_q <= hdr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_i.valid && hdr_i.ready) begin
      data_q <= hdr_i.data;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/ipv4rx_core.sv =====
// ----------------------------------------------------------------------------
// ipv4rx_core
// header state, checksum, interface match, verdict and result register
// ----------------------------------------------------------------------------
module ipv4rx_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ipv4rx_pkg::cfg_t      cfg_i,
  input  logic                  valid_i,
  input  ipv4rx_pkg::hdr_item_t data_i,
  output logic                  advance_o,
  ipv4rx_vrd_if.source          vrd_o
);
  import ipv4rx_pkg::*;

  logic [4:0]  word_pos_q, word_pos_d;
  logic [3:0]  hdr_len_q, hdr_len_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] frag_q, frag_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] dest_q, dest_d;
  logic [1:0]  src_q, src_d;
  logic        active_q, active_d;
  logic [31:0] rx_q, rx_d;
  logic [31:0] drop_q, drop_d;
  logic        out_valid_q, out_valid_d;
  vrd_item_t   out_q, res;

  logic        fire, start, emit, ver_bad, len_bad;
  logic [15:0] w;
  logic [4:0]  pos_b, last;
  logic [3:0]  hl_b;
  logic [15:0] sum_b, frag_b, frag_n, sum_n;
  logic [16:0] sum_wide;
  logic [7:0]  proto_b, proto_n;
  logic [31:0] dest_b, dest_n, src_mask;
  logic [1:0]  src_b, cnt_eff, match;
  verdict_e    fin_verdict;
  logic        fin_drop;

  assign advance_o = !out_valid_q || vrd_o.ready;
  assign fire      = valid_i && advance_o;

  always_comb begin
    start   = data_i.pkt_start;
    w       = data_i.hdr_word;
    ver_bad = w[15:12] != IP_VERSION;
    len_bad = (w[11:8] < MIN_IHL) || ((16'(w[11:8]) * IHL_UNIT) > data_i.buf_bytes);

    hl_b    = start ? w[11:8] : hdr_len_q;
    pos_b   = start ? 5'd0    : word_pos_q;
    sum_b   = start ? 16'd0   : sum_q;
    frag_b  = start ? 16'd0   : frag_q;
    proto_b = start ? 8'd0    : proto_q;
    dest_b  = start ? 32'd0   : dest_q;
    src_b   = start ? data_i.rx_iface : src_q;

    sum_wide = {1'b0, sum_b} + {1'b0, w};
    sum_n    = sum_wide[15:0] + 16'(sum_wide[16]);

    frag_n  = frag_b;
    proto_n = proto_b;
    dest_n  = dest_b;
    if (pos_b == POS_FRAG)   frag_n       = w;
    if (pos_b == POS_PROTO)  proto_n      = w[7:0];
    if (pos_b == POS_DST_HI) dest_n[31:16] = w;
    if (pos_b == POS_DST_LO) dest_n[15:0]  = w;

    last = {hl_b, 1'b0} - 5'd1;
  end

  // interface search, lowest index wins
  always_comb begin
    cnt_eff = (32'(cfg_i.iface_count) > NUM_IFACES) ? 2'(NUM_IFACES) : cfg_i.iface_count;
    match   = MATCH_NONE;
    for (int i = NUM_IFACES - 1; i >= 0; i--) begin
      if ((i < int'(cnt_eff)) &&
          ((cfg_i.addr[i] == '0) || (dest_n == cfg_i.addr[i]) ||
           (is_bcast(dest_n, cfg_i.mask[i]) &&
            ((dest_n & cfg_i.mask[i]) == (cfg_i.addr[i] & cfg_i.mask[i]))) ||
           (dest_n == ALL_ONES))) begin
        match = 2'(i);
      end
    end
    src_mask = (int'(src_b) < NUM_IFACES) ? cfg_i.mask[src_b[IDX_W-1:0]] : ALL_ONES;
  end

  always_comb begin
    fin_drop = 1'b1;
    priority if (sum_n != SUM_OK) begin
      fin_verdict = V_BADSUM;
    end else if (match == MATCH_NONE) begin
      fin_verdict = V_NOTUS;
      fin_drop    = 1'b0;
    end else if (frag_n[13:0] != '0) begin
      fin_verdict = V_FRAG;
    end else if (hl_b > MIN_IHL) begin
      fin_verdict = V_OPTS;
    end else if (proto_n == PROTO_UDP) begin
      fin_verdict = V_UDP;
      fin_drop    = 1'b0;
    end else if (proto_n == PROTO_ICMP) begin
      fin_verdict = V_ICMP;
      fin_drop    = 1'b0;
    end else if (proto_n == PROTO_TCP) begin
      fin_verdict = V_TCP;
      fin_drop    = 1'b0;
    end else if (is_bcast(dest_n, src_mask) || (dest_n[31:28] == MCAST_TOP)) begin
      fin_verdict = V_SILENT;
    end else begin
      fin_verdict = V_UNREACH;
    end
  end

  always_comb begin
    word_pos_d = word_pos_q;
    hdr_len_d  = hdr_len_q;
    sum_d      = sum_q;
    frag_d     = frag_q;
    proto_d    = proto_q;
    dest_d     = dest_q;
    src_d      = src_q;
    active_d   = active_q;
    rx_d       = rx_q;
    drop_d     = drop_q;
    emit       = 1'b0;
    res        = '0;
    res.match_iface = MATCH_NONE;

    if (fire && (start || active_q)) begin
      hdr_len_d = hl_b;
      src_d     = src_b;
      rx_d      = start ? rx_q + 32'd1 : rx_q;
      active_d  = 1'b1;
      priority if (start && ver_bad) begin
        emit        = 1'b1;
        res.verdict = V_BADVER;
      end else if (start && len_bad) begin
        emit        = 1'b1;
        res.verdict = V_SHORT;
      end else begin
        sum_d   = sum_n;
        frag_d  = frag_n;
        proto_d = proto_n;
        dest_d  = dest_n;
        if (pos_b < last) begin
          word_pos_d = pos_b + 5'd1;
        end else begin
          word_pos_d      = pos_b;
          emit            = 1'b1;
          res.verdict     = fin_verdict;
          res.protocol    = proto_n;
          res.match_iface = (fin_verdict == V_BADSUM) ? MATCH_NONE : match;
        end
      end
      if (start) begin
        if (ver_bad || len_bad) begin
          word_pos_d = '0;
          sum_d      = '0;
          frag_d     = '0;
          proto_d    = '0;
          dest_d     = '0;
        end
      end
      if (emit) begin
        active_d = 1'b0;
        if ((res.verdict == V_BADVER) || (res.verdict == V_SHORT) || fin_drop) begin
          drop_d = drop_q + 32'd1;
        end
      end
    end
    res.rx_total   = rx_d;
    res.drop_total = drop_d;

    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = fire && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_pos_q  <= '0;
      hdr_len_q   <= '0;
      sum_q       <= '0;
      frag_q      <= '0;
      proto_q     <= '0;
      dest_q      <= '0;
      src_q       <= '0;
      active_q    <= 1'b0;
      rx_q        <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      word_pos_q  <= word_pos_d;
      hdr_len_q   <= hdr_len_d;
      sum_q       <= sum_d;
      frag_q      <= frag_d;
      proto_q     <= proto_d;
      dest_q      <= dest_d;
      src_q       <= src_d;
      active_q    <= active_d;
      rx_q        <= rx_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_q <= res;
    end
  end

  assign vrd_o.valid = out_valid_q;
  assign vrd_o.data  = out_q;

endmodule
